@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/ic3_pkg.sv @@
package ic3_pkg;

  // Frame geometry defaults
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned KERNEL_SIZE   = 3;
  localparam int unsigned WIN_CELLS     = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned FRAC_BITS     = 12;

  // Field and register widths
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COEFF_W      = 16;
  localparam int unsigned COEFF_ROW_W  = KERNEL_SIZE * COEFF_W;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 12;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = COEFF_ROW_W;

  typedef logic [PIX_W-1:0]       pixel_t;
  typedef logic [COEFF_ROW_W-1:0] coeff_row_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_COEFF_TOP    = 3'd2;
  localparam cfg_idx_t CFG_COEFF_MIDDLE = 3'd3;
  localparam cfg_idx_t CFG_COEFF_BOTTOM = 3'd4;

  // Reset values: 1024 x 768 frame, identity kernel (1.0 in the center)
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 12'd768;
  localparam coeff_row_t COEFF_TOP_RST    = 48'h0000_0000_0000;
  localparam coeff_row_t COEFF_MIDDLE_RST = 48'h0000_1000_0000;
  localparam coeff_row_t COEFF_BOTTOM_RST = 48'h0000_0000_0000;

endpackage

@@ rtl/core/image_convolution_3x3_top.sv @@
// 3x3 convolution filter for a raster stream of 8-bit grey pixels. Each word
// on the slave side is either a pixel or, with tuser set, a drain word that
// pushes out one pending result of a finished frame. Interior pixels are
// replaced by the kernel-weighted sum of their 3x3 neighborhood (signed Q4.12
// coefficients, negative sums give 0, fraction truncated, saturated at 255);
// pixels on the frame border pass through. Results trail their pixels by one
// row plus one pixel, so after the last pixel of a frame either the clamped
// width + 1 drain words or the pixels of the next frame must follow; tlast marks
// the last result of a frame. The block takes one word per clock when not
// stalled: the line store is one memory holding both previous rows side by
// side, read once per word and written once per pixel. The user must write
// registers only while the stream is idle; the block does not enforce it.
module image_convolution_3x3_top #(
  parameter int unsigned MAX_WIDTH = ic3_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  ic3_pkg::pixel_t     s_axis_tdata,   // [7:0] pixel_in
  input  logic                s_axis_tuser,   // [0] drain
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output ic3_pkg::pixel_t     m_axis_tdata,   // [7:0] pixel_out
  output logic                m_axis_tlast,   // frame_last
  // register writes
  input  logic                cfg_we_i,
  input  ic3_pkg::cfg_idx_t   cfg_idx_i,
  input  ic3_pkg::cfg_data_t  cfg_data_i
);
  import ic3_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HW      = HEIGHT_REG_W;
  localparam int unsigned LS_W    = 2 * PIX_W;
  localparam int unsigned PROD_W  = PIX_W + 1 + COEFF_W;
  localparam int unsigned SUM_W   = PROD_W + 4;
  localparam int unsigned SH_W    = SUM_W - 1 - FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CENTER,
    KIND_CONV
  } kind_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  coeff_row_t              coeff_q [KERNEL_SIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      coeff_q[0] <= COEFF_TOP_RST;
      coeff_q[1] <= COEFF_MIDDLE_RST;
      coeff_q[2] <= COEFF_BOTTOM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i[HEIGHT_REG_W-1:0];
        CFG_COEFF_TOP:    coeff_q[0] <= cfg_data_i;
        CFG_COEFF_MIDDLE: coeff_q[1] <= cfg_data_i;
        CFG_COEFF_BOTTOM: coeff_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (int'(width_q) < KERNEL_SIZE) begin
      w_eff = WW'(KERNEL_SIZE);
    end else if (int'(width_q) > int'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (int'(height_q) < KERNEL_SIZE) ? HW'(KERNEL_SIZE) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: each stage loads when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, m_valid_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic s_acc, s1_adv, s2_adv, s3_adv;

  assign out_rdy       = !m_valid_q || m_axis_tready;
  assign s3_rdy        = !s3_valid_q || out_rdy;
  assign s2_rdy        = !s2_valid_q || s3_rdy;
  assign s1_rdy        = !s1_valid_q || s2_rdy;
  assign s_axis_tready = s1_rdy;

  assign s_acc  = s_axis_tvalid && s1_rdy;
  assign s1_adv = s1_valid_q && s2_rdy;
  assign s2_adv = s2_valid_q && s3_rdy;
  assign s3_adv = s3_valid_q && out_rdy;

  // ---------------------------------------------------------------------------
  // Position counters and result decision for the incoming word
  // ---------------------------------------------------------------------------
  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] pend_q, pend_d;

  logic [AW:0]   col_inc;
  logic [HW:0]   row_inc;
  logic [WW:0]   ddiff;
  logic          drain_hit;

  logic          ld_valid;
  kind_e         ld_kind;
  logic          ld_last;
  logic          ld_zero;
  logic [AW-1:0] rd_addr;

  assign col_inc   = {1'b0, col_q} + (AW+1)'(1);
  assign row_inc   = {1'b0, row_q} + (HW+1)'(1);
  // Column of the row that a drain word shifts into the window
  assign ddiff     = {1'b0, w_eff} + (WW+1)'(1) - {1'b0, pend_q};
  assign drain_hit = !ddiff[WW] && (int'(ddiff[WW-1:0]) < int'(MAX_WIDTH));

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    ld_valid = 1'b0;
    ld_kind  = KIND_NONE;
    ld_last  = 1'b0;
    ld_zero  = 1'b0;
    rd_addr  = col_q;

    if (s_axis_tuser) begin
      // Drain: ignored when nothing is pending
      if (pend_q != '0) begin
        ld_valid = 1'b1;
        ld_kind  = KIND_CENTER;
        ld_last  = (pend_q == WW'(1));
        ld_zero  = !drain_hit;
        rd_addr  = ddiff[AW-1:0];
        pend_d   = pend_q - WW'(1);
      end
    end else begin
      ld_valid = 1'b1;
      if (pend_q != '0) begin
        ld_kind = KIND_CENTER;
        ld_last = (pend_q == WW'(1));
        pend_d  = pend_q - WW'(1);
      end else if (row_q >= HW'(2) || (row_q == HW'(1) && col_q >= AW'(1))) begin
        ld_kind = (row_q >= HW'(2) && col_q >= AW'(2)) ? KIND_CONV : KIND_CENTER;
      end

      // Advance column, row and frame
      if (int'(col_inc) >= int'(w_eff)) begin
        col_d = '0;
        if (int'(row_inc) >= int'(h_eff)) begin
          row_d  = '0;
          pend_d = w_eff + WW'(1);
        end else begin
          row_d = row_inc[HW-1:0];
        end
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else if (s_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read; entry holds {row before previous, previous row}
  // ---------------------------------------------------------------------------
  logic [LS_W-1:0] line_mem [MAX_WIDTH];
  logic [LS_W-1:0] rd_q;
  logic [LS_W-1:0] byp_data_q;
  logic            byp_q;

  kind_e           s1_kind_q;
  logic            s1_last_q;
  logic            s1_drain_q;
  logic            s1_zero_q;
  pixel_t          s1_pix_q;
  logic [AW-1:0]   s1_addr_q;

  logic [LS_W-1:0] s1_rd;
  logic            mem_we;
  logic [LS_W-1:0] mem_wdata;

  // Forward a write that lands on the address read in the same cycle
  assign s1_rd     = byp_q ? byp_data_q : rd_q;
  assign mem_we    = s1_adv && !s1_drain_q;
  assign mem_wdata = {s1_rd[PIX_W-1:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_addr_q] <= mem_wdata;
    end
    if (s_acc) begin
      rd_q       <= line_mem[rd_addr];
      byp_q      <= mem_we && (s1_addr_q == rd_addr);
      byp_data_q <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= ld_valid;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_kind_q  <= ld_kind;
      s1_last_q  <= ld_last;
      s1_drain_q <= s_axis_tuser;
      s1_zero_q  <= ld_zero;
      s1_pix_q   <= s_axis_tdata;
      s1_addr_q  <= rd_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window shift; words without a result stop here
  // ---------------------------------------------------------------------------
  pixel_t win_q [WIN_CELLS];
  pixel_t win_d [WIN_CELLS];
  pixel_t col_top, col_mid, col_bot;
  kind_e  s2_kind_q;
  logic   s2_last_q;

  always_comb begin
    if (s1_drain_q) begin
      col_top = '0;
      col_mid = s1_zero_q ? '0 : s1_rd[PIX_W-1:0];
      col_bot = '0;
    end else begin
      col_top = s1_rd[LS_W-1:PIX_W];
      col_mid = s1_rd[PIX_W-1:0];
      col_bot = s1_pix_q;
    end
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win_d[r*KERNEL_SIZE + c] = win_q[r*KERNEL_SIZE + c + 1];
      end
    end
    win_d[KERNEL_SIZE - 1]                 = col_top;
    win_d[2*KERNEL_SIZE - 1]               = col_mid;
    win_d[KERNEL_SIZE*KERNEL_SIZE - 1]     = col_bot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int i = 0; i < WIN_CELLS; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        s2_valid_q <= (s1_kind_q != KIND_NONE);
        win_q      <= win_d;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_kind_q <= s1_kind_q;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: nine products of window and kernel
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d [WIN_CELLS];
  logic signed [PROD_W-1:0] prod_q [WIN_CELLS];
  pixel_t                   s3_center_q;
  kind_e                    s3_kind_q;
  logic                     s3_last_q;

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        prod_d[r*KERNEL_SIZE + c] =
          PROD_W'($signed({1'b0, win_q[r*KERNEL_SIZE + c]})) *
          PROD_W'($signed(coeff_q[r][c*COEFF_W +: COEFF_W]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s3_valid_q <= 1'b1;
    end else if (s3_adv) begin
      s3_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      prod_q      <= prod_d;
      s3_center_q <= win_q[(WIN_CELLS - 1) / 2];
      s3_kind_q   <= s2_kind_q;
      s3_last_q   <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: sum, drop fraction, saturate, pick filtered or border pixel
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum;
  logic [SH_W-1:0]         sum_int;
  pixel_t                  conv_pix;
  pixel_t                  res_pix;
  pixel_t                  m_data_q;
  logic                    m_last_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      sum = sum + {{(SUM_W-PROD_W){prod_q[i][PROD_W-1]}}, prod_q[i]};
    end
    sum_int = sum[SUM_W-2:FRAC_BITS];
    if (sum[SUM_W-1]) begin
      conv_pix = '0;
    end else if (|sum_int[SH_W-1:PIX_W]) begin
      conv_pix = '1;
    end else begin
      conv_pix = sum_int[PIX_W-1:0];
    end
    res_pix = (s3_kind_q == KIND_CONV) ? conv_pix : s3_center_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s3_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      m_data_q <= res_pix;
      m_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_col_in_range, clk_i, rst_ni, int'(col_q) < int'(MAX_WIDTH), "column out of range")
  `ASSERT_NEXT(a_idle_drain, clk_i, rst_ni, s_acc && s_axis_tuser && (pend_q == '0), !s1_valid_q && $stable(pend_q), "idle drain changed state")
  `ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s2_rdy, s1_valid_q && $stable(s1_addr_q) && (rd_q === $past(rd_q)), "stalled line store word lost")
  `ASSERT_IMPL(a_full_stall, clk_i, rst_ni, s1_valid_q && s2_valid_q && s3_valid_q && m_valid_q && !m_axis_tready, !s_axis_tready, "word taken into a full pipeline")

endmodule

@@ bench/image_convolution_3x3_top_tb.sv @@
`timescale 1ns / 1ps

module image_convolution_3x3_top_tb;
  import ic3_pkg::*;

  localparam int unsigned MAXW         = MAX_WIDTH_DEF;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned DIR_ROWS     = 26;

  localparam cfg_idx_t KERNEL_IDX [3] = '{CFG_COEFF_TOP, CFG_COEFF_MIDDLE, CFG_COEFF_BOTTOM};

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } out_word_t;

  typedef enum logic [1:0] { EXP_NONE, EXP_WORD, EXP_MODEL } exp_kind_e;

  typedef struct packed {
    logic      drain;
    pixel_t    pix;
    exp_kind_e kind;
    pixel_t    want;
    logic      want_last;
  } dir_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  pixel_t     s_axis_tdata  = '0;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  pixel_t     m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_we_i      = 1'b0;
  cfg_idx_t   cfg_idx_i     = CFG_IMAGE_WIDTH;
  cfg_data_t  cfg_data_i    = '0;

  // Filter state as seen from outside
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  coeff_row_t              kernel_rows [3];
  pixel_t                  line_mem [2*MAXW];
  pixel_t                  window [9];
  int unsigned             col_pos, row_pos, pending;

  out_word_t   filtered_q [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned word_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 77;

  // Identity kernel, 3x3 frames: results trail the pixels by four words
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{1'b1, 8'h00, EXP_NONE,  8'h00, 1'b0},  // drain with nothing pending
    '{1'b0, 8'h00, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'hFF, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'h01, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'h80, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'h7F, EXP_WORD,  8'h00, 1'b0},
    '{1'b0, 8'hAA, EXP_WORD,  8'hFF, 1'b0},
    '{1'b0, 8'h55, EXP_WORD,  8'h01, 1'b0},
    '{1'b0, 8'hFE, EXP_WORD,  8'h80, 1'b0},
    '{1'b0, 8'h10, EXP_WORD,  8'h7F, 1'b0},
    '{1'b1, 8'h00, EXP_WORD,  8'hAA, 1'b0},
    '{1'b1, 8'hFF, EXP_WORD,  8'h55, 1'b0},
    // next frame after a partial drain
    '{1'b0, 8'h33, EXP_MODEL, 8'h00, 1'b0},
    '{1'b0, 8'hCC, EXP_MODEL, 8'h00, 1'b0},
    '{1'b0, 8'h0F, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'hF0, EXP_NONE,  8'h00, 1'b0},
    '{1'b0, 8'h5A, EXP_WORD,  8'h33, 1'b0},
    '{1'b0, 8'hA5, EXP_WORD,  8'hCC, 1'b0},
    '{1'b0, 8'h3C, EXP_WORD,  8'h0F, 1'b0},
    '{1'b0, 8'hC3, EXP_WORD,  8'hF0, 1'b0},
    '{1'b0, 8'h99, EXP_WORD,  8'h5A, 1'b0},
    '{1'b1, 8'h00, EXP_WORD,  8'hA5, 1'b0},
    '{1'b1, 8'h00, EXP_WORD,  8'h3C, 1'b0},
    '{1'b1, 8'h00, EXP_WORD,  8'hC3, 1'b0},
    '{1'b1, 8'h00, EXP_WORD,  8'h99, 1'b1},
    '{1'b1, 8'hFF, EXP_NONE,  8'h00, 1'b0}
  };

  image_convolution_3x3_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_width();
    int unsigned v;
    v = width_reg;
    if (v < 3) v = 3;
    if (v > MAXW) v = MAXW;
    return v;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Weighted sum of the window, clamped to 0..255, fraction dropped
  function automatic pixel_t kernel_sum();
    longint                     acc;
    logic signed [COEFF_W-1:0]  k;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k = kernel_rows[r][COEFF_W*c +: COEFF_W];
        acc += longint'(k) * longint'(window[3*r+c]);
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> FRAC_BITS;
    return (acc > 255) ? 8'hFF : pixel_t'(acc);
  endfunction

  function automatic void slide_window(input pixel_t top, input pixel_t mid, input pixel_t bot);
    for (int r = 0; r < 3; r++) begin
      window[3*r]   = window[3*r+1];
      window[3*r+1] = window[3*r+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = bot;
  endfunction

  // Advance the filter by one accepted word and return the word it emits
  function automatic void filter_step(input logic drn, input pixel_t pix,
                                      output logic got, output out_word_t res);
    int unsigned w, h, x, y;
    pixel_t      a, b;
    w   = active_width();
    h   = active_height();
    got = 1'b0;
    res = '0;
    if (drn) begin
      if (pending != 0) begin
        x = (w + 1 - pending) & 32'hFFFF;
        a = (x < MAXW) ? line_mem[x] : '0;
        slide_window('0, a, '0);
        pending--;
        got      = 1'b1;
        res.pix  = window[4];
        res.last = (pending == 0);
      end
    end else begin
      x = (col_pos < MAXW) ? col_pos : 0;
      y = row_pos;
      a = line_mem[x];
      b = line_mem[MAXW+x];
      line_mem[MAXW+x] = a;
      line_mem[x]      = pix;
      slide_window(b, a, pix);
      if (pending != 0) begin
        pending--;
        got      = 1'b1;
        res.pix  = window[4];
        res.last = (pending == 0);
      end else if (y >= 2 || (y == 1 && x >= 1)) begin
        got      = 1'b1;
        res.pix  = (y >= 2 && x >= 2) ? kernel_sum() : window[4];
        res.last = 1'b0;
      end
      col_pos = x + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = y + 1;
        if (row_pos >= h) begin
          row_pos = 0;
          pending = w + 1;
        end
      end
    end
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic coeff_row_t random_kernel_row();
    coeff_row_t row;
    int         c;
    case ($urandom_range(0, 5))
      0: row = {3{16'h8000}};
      1: row = {3{16'h7FFF}};
      2: row = coeff_row_t'({$urandom(), $urandom()});
      3: row = '0;
      default: begin
        for (int i = 0; i < 3; i++) begin
          c = int'($urandom_range(0, 3072)) - 1536;
          row[COEFF_W*i +: COEFF_W] = 16'(c);
        end
      end
    endcase
    return row;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg      = val[WIDTH_REG_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg     = val[HEIGHT_REG_W-1:0];
      CFG_COEFF_TOP:    kernel_rows[0] = val[COEFF_ROW_W-1:0];
      CFG_COEFF_MIDDLE: kernel_rows[1] = val[COEFF_ROW_W-1:0];
      CFG_COEFF_BOTTOM: kernel_rows[2] = val[COEFF_ROW_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one word, hold it until accepted, then predict its result
  task automatic push_word(input logic drn, input pixel_t pix,
                           output logic got, output out_word_t res);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= drn;
    do @(posedge clk_i); while (!s_axis_tready);
    filter_step(drn, pix, got, res);
    if (!(drn && !got)) word_cnt++;
    if (word_cnt < 180) begin
      send_idle_pct = 29;
      recv_idle_pct = 77;
    end else if (word_cnt < 360) begin
      send_idle_pct = 77;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic feed(input logic drn, input pixel_t pix);
    logic      got;
    out_word_t res;
    push_word(drn, pix, got, res);
    if (got) filtered_q.push_back(res);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic drain_frame();
    while (pending != 0) feed(1'b1, random_pixel());
  endtask

  // Send pixels until the frame counters wrap, with noise and mid-frame writes
  task automatic run_frame(input logic allow_change);
    int unsigned j;
    do begin
      if (pending == 0 && $urandom_range(0, 99) < 3) feed(1'b1, random_pixel());
      if (allow_change && pending == 0 && $urandom_range(0, 149) == 0) begin
        wait_idle();
        case ($urandom_range(0, 2))
          0: write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 8));
          1: write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, active_width()));
          default: begin
            j = $urandom_range(0, 2);
            write_reg(KERNEL_IDX[j], random_kernel_row());
          end
        endcase
      end
      feed(1'b0, random_pixel());
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk_i) begin : out_check
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h last %0b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want.pix)
          report_mismatch($sformatf("pixel %02h, want %02h", m_axis_tdata, want.pix));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("** image_convolution_3x3_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic        got;
    out_word_t   res;
    logic        first;
    int unsigned nfr, k;

    width_reg      = WIDTH_RST;
    height_reg     = HEIGHT_RST;
    kernel_rows[0] = COEFF_TOP_RST;
    kernel_rows[1] = COEFF_MIDDLE_RST;
    kernel_rows[2] = COEFF_BOTTOM_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (window[i]) window[i] = '0;
    col_pos = 0;
    row_pos = 0;
    pending = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset kernel, width and height below range
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    foreach (dir_tbl[i]) begin
      push_word(dir_tbl[i].drain, dir_tbl[i].pix, got, res);
      case (dir_tbl[i].kind)
        EXP_WORD:  filtered_q.push_back(out_word_t'{dir_tbl[i].want, dir_tbl[i].want_last});
        EXP_MODEL: if (got) filtered_q.push_back(res);
        default: ;
      endcase
    end
    wait_idle();

    // Random settings, each with a few small frames
    first = 1'b1;
    while (word_cnt < DIR_ROWS + RANDOM_WORDS) begin
      if (first || $urandom_range(0, 99) < 70) write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, 10));
      if (first || $urandom_range(0, 99) < 70) write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 6));
      foreach (KERNEL_IDX[j]) begin
        if (first || $urandom_range(0, 99) < 60) write_reg(KERNEL_IDX[j], random_kernel_row());
      end
      first = 1'b0;
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        run_frame(1'b1);
        k = (f == nfr - 1) ? 0 : $urandom_range(0, 2);
        case (k)
          0: begin
            drain_frame();
            if ($urandom_range(0, 99) < 30) feed(1'b1, random_pixel());
          end
          1: begin
            // partial drain, then the next frame takes over
            k = $urandom_range(1, pending - 1);
            repeat (k) feed(1'b1, random_pixel());
          end
          default: ;  // back-to-back frames
        endcase
      end
      wait_idle();
    end

    if (mismatch_cnt == 0 && filtered_q.size() == 0) begin
      $display("** image_convolution_3x3_top: PASSED **");
    end else begin
      $display("** image_convolution_3x3_top: FAILED **");
    end
    $finish;
  end

endmodule
